// File: design/dlle_pkg.sv
// Shared types and constants of the doubly linked list engine.
package dlle_pkg;

    // Default pool geometry.
    localparam int DLLE_POOL_ENTRIES = 16;
    localparam int DLLE_DATA_WIDTH   = 32;

    // Fixed widths of the transfer fields.
    localparam int OP_W     = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int HANDLE_W = 4;
    localparam int COUNT_W  = 4;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_POOL_FULL  = 3'd1,
        STAT_LIST_EMPTY = 3'd2,
        STAT_NOT_FOUND  = 3'd3,
        STAT_BAD_HANDLE = 3'd4
    } t_status;

    // Source of the working node index latched when an operation is taken.
    typedef enum logic [1:0] {
        TGT_SENTINEL,
        TGT_FRONT,
        TGT_BACK,
        TGT_POS
    } t_tgt_sel;

    // Source of the handle reported in the result.
    typedef enum logic [1:0] {
        HSEL_NONE,
        HSEL_FREE_HEAD,
        HSEL_TARGET
    } t_hsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;      // latch value and working node
        t_tgt_sel tgt_sel;
        logic     rd_fh;       // next-link read at the free head instead of the node
        logic     ins_node;    // allocate and fill the new node
        logic     ins_link;    // splice the new node between its neighbors
        logic     era_unlink;  // bridge the neighbors of the working node
        logic     era_free;    // push the working node onto the free list
        logic     find_step;   // advance the walk to the next node
        logic     clear;       // return the pool to its reset arrangement
        logic     res_load;    // capture status and handle of the result
        t_status  res_status;
        t_hsel    res_hsel;
        logic     res_rm;      // report the data read from the working node
        logic     out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_pos_zero;
        logic in_pos_oob;
        logic list_empty;
        logic fh_zero;
        logic tgt_zero;
        logic live_ok;
        logic hit;
    } t_stat;

endpackage

// File: design/dlle_ctrl.sv
// Operation sequencer of the doubly linked list engine.
module dlle_ctrl
    import dlle_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_stat           i_stat,
    output t_cmd            o_cmd
);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK     = 4'd0,
        OP_PUSH_FRONT    = 4'd1,
        OP_POP_BACK      = 4'd2,
        OP_POP_FRONT     = 4'd3,
        OP_INSERT_BEFORE = 4'd4,
        OP_ERASE         = 4'd5,
        OP_FIND          = 4'd6,
        OP_QUERY         = 4'd7,
        OP_CLEAR         = 4'd8
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_LINK,
        ST_ERA_RD,
        ST_ERA_UNLINK,
        ST_ERA_FREE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    case (i_operation)
                        OP_PUSH_BACK: begin
                            cmd.tgt_sel = TGT_SENTINEL;
                            n_state     = ST_INS_RD;
                        end
                        OP_PUSH_FRONT: begin
                            cmd.tgt_sel = TGT_FRONT;
                            n_state     = ST_INS_RD;
                        end
                        OP_INSERT_BEFORE: begin
                            cmd.tgt_sel = TGT_POS;
                            if (i_stat.in_pos_oob) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = STAT_BAD_HANDLE;
                                n_state        = ST_DONE;
                            end else begin
                                n_state = ST_INS_RD;
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT: begin
                            cmd.tgt_sel = (i_operation == OP_POP_BACK) ? TGT_BACK : TGT_FRONT;
                            if (i_stat.list_empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = STAT_LIST_EMPTY;
                                n_state        = ST_DONE;
                            end else begin
                                n_state = ST_ERA_RD;
                            end
                        end
                        OP_ERASE: begin
                            cmd.tgt_sel = TGT_POS;
                            if (i_stat.in_pos_zero || i_stat.in_pos_oob) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = STAT_BAD_HANDLE;
                                n_state        = ST_DONE;
                            end else begin
                                n_state = ST_ERA_RD;
                            end
                        end
                        OP_FIND: begin
                            cmd.tgt_sel = TGT_FRONT;
                            n_state     = ST_FIND_RD;
                        end
                        OP_CLEAR: begin
                            cmd.clear      = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_OK;
                            n_state        = ST_DONE;
                        end
                        default: begin
                            // Query and unused codes only report the count.
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_OK;
                            n_state        = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                cmd.rd_fh = 1'b1;
                n_state   = ST_INS_WR;
            end
            ST_INS_WR: begin
                cmd.res_load = 1'b1;
                // The handle is checked before the pool is checked for space.
                if (!i_stat.tgt_zero && !i_stat.live_ok) begin
                    cmd.res_status = STAT_BAD_HANDLE;
                    n_state        = ST_DONE;
                end else if (i_stat.fh_zero) begin
                    cmd.res_status = STAT_POOL_FULL;
                    n_state        = ST_DONE;
                end else begin
                    cmd.ins_node   = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_hsel   = HSEL_FREE_HEAD;
                    n_state        = ST_INS_LINK;
                end
            end
            ST_INS_LINK: begin
                cmd.ins_link = 1'b1;
                n_state      = ST_DONE;
            end
            ST_ERA_RD: begin
                n_state = ST_ERA_UNLINK;
            end
            ST_ERA_UNLINK: begin
                cmd.res_load = 1'b1;
                if (!i_stat.live_ok) begin
                    cmd.res_status = STAT_BAD_HANDLE;
                    n_state        = ST_DONE;
                end else begin
                    cmd.era_unlink = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_hsel   = HSEL_TARGET;
                    cmd.res_rm     = 1'b1;
                    n_state        = ST_ERA_FREE;
                end
            end
            ST_ERA_FREE: begin
                cmd.era_free = 1'b1;
                n_state      = ST_DONE;
            end
            ST_FIND_RD: begin
                if (i_stat.tgt_zero) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP: begin
                if (i_stat.hit) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_hsel   = HSEL_TARGET;
                    n_state        = ST_DONE;
                end else begin
                    cmd.find_step = 1'b1;
                    n_state       = ST_FIND_RD;
                end
            end
            ST_DONE: begin
                // Wait for the output register to be free.
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed transfers.
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: design/dlle_dpath.sv
// Node pool memories, list registers and result registers of the engine.
module dlle_dpath
    import dlle_pkg::*;
#(
    parameter int POOL_ENTRIES = DLLE_POOL_ENTRIES,
    parameter int DATA_WIDTH   = DLLE_DATA_WIDTH
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    output logic [2:0]                 o_status,
    output logic [HANDLE_W-1:0]        o_handle,
    output logic signed [VALUE_W-1:0]  o_removed_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_is_empty
);

    localparam int IW = $clog2(POOL_ENTRIES);
    localparam logic [IW:0] POOL_END = (IW + 1)'(POOL_ENTRIES);

    typedef logic [IW-1:0] t_idx;

    // List registers: the sentinel links live here, not in the memories.
    t_idx          r_front, r_back, r_fh, r_count;
    logic [IW:0]   r_wmark;   // entries at and above it were never allocated

    // Working registers of the current operation.
    t_idx                  r_tgt, r_new, r_before;
    logic [DATA_WIDTH-1:0] r_val;

    // Result staging and output registers.
    t_status               r_res_status;
    t_idx                  r_res_handle;
    logic [VALUE_W-1:0]    r_res_removed;
    t_status               r_out_status;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [VALUE_W-1:0]    r_out_removed;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;

    // Pool memories and their registered read data.
    t_idx                  r_next_mem [POOL_ENTRIES];
    t_idx                  r_prev_mem [POOL_ENTRIES];
    logic [DATA_WIDTH-1:0] r_data_mem [POOL_ENTRIES];
    logic                  r_live_mem [POOL_ENTRIES];
    t_idx                  r_next_q, r_prev_q;
    logic [DATA_WIDTH-1:0] r_data_q;
    logic                  r_live_q;

    logic [DATA_WIDTH-1:0] in_val_dw;
    logic [VALUE_W-1:0]    data_q_wide;
    logic [IW+POS_W-1:0]   pos_ext;
    t_idx                  in_pos_idx, tgt_mux, ins_prev, fh_next, res_handle;
    logic [IW:0]           fh_ext, fh_inc;
    logic                  fh_untouched;
    logic [IW+HANDLE_W-1:0] handle_ext;
    logic [IW+COUNT_W-1:0]  count_ext;

    logic                  next_we, prev_we, data_we, live_we, live_wd;
    t_idx                  next_wa, next_wd, prev_wa, prev_wd, next_ra;

    // Value to storage width and stored data back to the result width.
    if (DATA_WIDTH > VALUE_W) begin : g_wide
        assign in_val_dw   = {{(DATA_WIDTH - VALUE_W){1'b0}}, i_value};
        assign data_q_wide = r_data_q[VALUE_W-1:0];
    end else if (DATA_WIDTH == VALUE_W) begin : g_equal
        assign in_val_dw   = i_value;
        assign data_q_wide = r_data_q;
    end else begin : g_narrow
        assign in_val_dw   = i_value[DATA_WIDTH-1:0];
        assign data_q_wide = {{(VALUE_W - DATA_WIDTH){r_data_q[DATA_WIDTH-1]}}, r_data_q};
    end

    // Position handle as a pool index, with its range check.
    assign pos_ext    = {{IW{1'b0}}, i_position};
    assign in_pos_idx = pos_ext[IW-1:0];

    always_comb begin
        case (i_cmd.tgt_sel)
            TGT_SENTINEL: tgt_mux = '0;
            TGT_FRONT:    tgt_mux = r_front;
            TGT_BACK:     tgt_mux = r_back;
            TGT_POS:      tgt_mux = in_pos_idx;
            default:      tgt_mux = '0;
        endcase
    end

    // Status toward the controller.
    assign o_stat.in_pos_zero = (i_position == '0);
    assign o_stat.in_pos_oob  = (pos_ext >= (IW + POS_W)'(POOL_ENTRIES));
    assign o_stat.list_empty  = (r_count == '0) || (r_front == '0);
    assign o_stat.fh_zero     = (r_fh == '0);
    assign o_stat.tgt_zero    = (r_tgt == '0);
    assign o_stat.live_ok     = r_live_q && ({1'b0, r_tgt} < r_wmark);
    assign o_stat.hit         = (r_data_q == r_val);

    // Allocation: a never-used free head chains to the next index in order.
    assign fh_ext       = {1'b0, r_fh};
    assign fh_untouched = (fh_ext == r_wmark);
    assign fh_inc       = fh_ext + 1'b1;
    assign fh_next      = fh_untouched ? ((fh_inc == POOL_END) ? '0 : fh_inc[IW-1:0])
                                       : r_next_q;
    assign ins_prev     = (r_tgt == '0) ? r_back : r_prev_q;

    // Next-link memory write port.
    always_comb begin
        next_we = 1'b0;
        next_wa = r_tgt;
        next_wd = r_tgt;
        if (i_cmd.ins_node) begin
            next_we = 1'b1;
            next_wa = r_fh;
            next_wd = r_tgt;
        end else if (i_cmd.ins_link && (r_before != '0)) begin
            next_we = 1'b1;
            next_wa = r_before;
            next_wd = r_new;
        end else if (i_cmd.era_unlink && (r_prev_q != '0)) begin
            next_we = 1'b1;
            next_wa = r_prev_q;
            next_wd = r_next_q;
        end else if (i_cmd.era_free) begin
            next_we = 1'b1;
            next_wa = r_tgt;
            next_wd = r_fh;
        end
    end

    // Prev-link memory write port.
    always_comb begin
        prev_we = 1'b0;
        prev_wa = r_tgt;
        prev_wd = r_new;
        if (i_cmd.ins_node) begin
            prev_we = 1'b1;
            prev_wa = r_fh;
            prev_wd = ins_prev;
        end else if (i_cmd.ins_link && (r_tgt != '0)) begin
            prev_we = 1'b1;
            prev_wa = r_tgt;
            prev_wd = r_new;
        end else if (i_cmd.era_unlink && (r_next_q != '0)) begin
            prev_we = 1'b1;
            prev_wa = r_next_q;
            prev_wd = r_prev_q;
        end
    end

    // Data and live memory write ports, and the next-link read address.
    assign data_we = i_cmd.ins_node;
    assign live_we = i_cmd.ins_node || i_cmd.era_unlink;
    assign live_wd = i_cmd.ins_node;
    assign next_ra = i_cmd.rd_fh ? r_fh : r_tgt;

    // Pool memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        r_next_q <= r_next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        r_prev_q <= r_prev_mem[r_tgt];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[r_fh] <= r_val;
        end
        r_data_q <= r_data_mem[r_tgt];
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            r_live_mem[i_cmd.ins_node ? r_fh : r_tgt] <= live_wd;
        end
        r_live_q <= r_live_mem[r_tgt];
    end

    // Sentinel links, free head, allocation mark and node count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_fh    <= IW'(1);
            r_wmark <= (IW + 1)'(1);
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_front <= '0;
            r_back  <= '0;
            r_fh    <= IW'(1);
            r_wmark <= (IW + 1)'(1);
            r_count <= '0;
        end else begin
            if (i_cmd.ins_node) begin
                r_fh    <= fh_next;
                r_count <= r_count + 1'b1;
                if (fh_untouched) begin
                    r_wmark <= fh_inc;
                end
            end
            if (i_cmd.ins_link) begin
                if (r_tgt == '0) begin
                    r_back <= r_new;
                end
                if (r_before == '0) begin
                    r_front <= r_new;
                end
            end
            if (i_cmd.era_unlink) begin
                if (r_prev_q == '0) begin
                    r_front <= r_next_q;
                end
                if (r_next_q == '0) begin
                    r_back <= r_prev_q;
                end
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (i_cmd.era_free) begin
                r_fh <= r_tgt;
            end
        end
    end

    // Result handle selection.
    always_comb begin
        case (i_cmd.res_hsel)
            HSEL_NONE:      res_handle = '0;
            HSEL_FREE_HEAD: res_handle = r_fh;
            HSEL_TARGET:    res_handle = r_tgt;
            default:        res_handle = '0;
        endcase
    end

    // Working registers and result staging.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tgt <= tgt_mux;
            r_val <= in_val_dw;
        end else if (i_cmd.find_step) begin
            r_tgt <= r_next_q;
        end
        if (i_cmd.ins_node) begin
            r_new    <= r_fh;
            r_before <= ins_prev;
        end
        if (i_cmd.res_load) begin
            r_res_status  <= i_cmd.res_status;
            r_res_handle  <= res_handle;
            r_res_removed <= i_cmd.res_rm ? data_q_wide : '0;
        end
    end

    // Output register.
    assign handle_ext = {{HANDLE_W{1'b0}}, r_res_handle};
    assign count_ext  = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_handle  <= handle_ext[HANDLE_W-1:0];
            r_out_removed <= r_res_removed;
            r_out_count   <= count_ext[COUNT_W-1:0];
            r_out_empty   <= (r_count == '0);
        end
    end

    assign o_status        = r_out_status;
    assign o_handle        = r_out_handle;
    assign o_removed_value = r_out_removed;
    assign o_count         = r_out_count;
    assign o_is_empty      = r_out_empty;

endmodule

// File: design/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine: sequencer plus pool datapath.
//
//   channel  dir  payload                                        transfer when
//   in       in   i_operation, i_value, i_position               i_in_valid & o_in_ready
//   out      out  o_status, o_handle, o_removed_value, o_count,  o_out_valid & i_out_ready
//                 o_is_empty
//
// Query, clear, unused codes, an empty pop, an erase at the sentinel and a handle
// out of range go from the transfer in straight to the result; push, insert, pop
// and erase pass through transfer in, read, update, relink, result load, and a full
// pool or a handle that is not live skips the relink. Find reads and compares one node after another from the front.
// Reset is synchronous and active low and needs no clearing pass over the pool;
// a stalled output holds the next item at its final step until the register is free.
module doubly_linked_list_engine
    import dlle_pkg::*;
#(
    parameter int POOL_ENTRIES = DLLE_POOL_ENTRIES,
    parameter int DATA_WIDTH   = DLLE_DATA_WIDTH
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_status,
    output logic [HANDLE_W-1:0]        o_handle,
    output logic signed [VALUE_W-1:0]  o_removed_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_is_empty
);

    t_cmd  cmd;
    t_stat stat;

    // Operation sequencer.
    dlle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Pool memories and list registers.
    dlle_dpath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_status        (o_status),
        .o_handle        (o_handle),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty)
    );

endmodule

// File: design/dlle_checker.sv
// Port-level assertions for the doubly linked list engine and their binding.
module dlle_checker
    import dlle_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic [2:0]                 o_status,
    input  logic [HANDLE_W-1:0]        o_handle,
    input  logic signed [VALUE_W-1:0]  o_removed_value,
    input  logic [COUNT_W-1:0]         o_count,
    input  logic                       o_is_empty
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
            $stable(o_handle) && $stable(o_removed_value) && $stable(o_count) &&
            $stable(o_is_empty))
        else $error("result changed or dropped while stalled");

    // A failed operation reports neither a handle nor a removed value.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_OK) |-> (o_handle == '0) && (o_removed_value == '0))
        else $error("failed operation carries a handle or data");

    // An empty list has a zero count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_count == '0))
        else $error("empty flag with nonzero count");

    // A pop refused for an empty list leaves the list empty.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_LIST_EMPTY) |-> o_is_empty)
        else $error("list-empty status on a nonempty list");

    // One operation at a time: the engine is busy right after a transfer in.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second operation taken before the first finished");

endmodule

bind doubly_linked_list_engine dlle_checker u_checker (.*);

// File: dv/dlle_tb_pkg.sv
// Operation codes and handle constants shared by the list engine testbench files.
`timescale 1ns / 100ps
package dlle_tb_pkg;

    // List operations carried by one input transfer.
    typedef enum logic [3:0] {
        OP_PUSH_BACK     = 4'd0,
        OP_PUSH_FRONT    = 4'd1,
        OP_POP_BACK      = 4'd2,
        OP_POP_FRONT     = 4'd3,
        OP_INSERT_BEFORE = 4'd4,
        OP_ERASE         = 4'd5,
        OP_FIND          = 4'd6,
        OP_QUERY         = 4'd7,
        OP_CLEAR         = 4'd8
    } t_list_op;

    // Highest code the operation field can carry; codes above OP_CLEAR are unused.
    localparam logic [3:0] OP_CODE_MAX = 4'hF;

    // Handle of the sentinel entry, which also marks the end of the free chain.
    localparam logic [3:0] SENTINEL = 4'd0;

endpackage

// File: dv/list_result_checker.sv
// Watches both channels of the list engine, predicts each result and compares it.
`timescale 1ns / 100ps
module list_result_checker
    import dlle_pkg::*;
    import dlle_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2:0]          i_status,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [VALUE_W-1:0]  i_removed_value,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic                i_is_empty,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  handle;
        logic [VALUE_W-1:0]   removed;
        logic [COUNT_W-1:0]   count;
        logic                 empty;
    } t_list_result;

    // Private copy of the node pool.
    logic [HANDLE_W-1:0] link_next [DLLE_POOL_ENTRIES];
    logic [HANDLE_W-1:0] link_prev [DLLE_POOL_ENTRIES];
    logic [VALUE_W-1:0]  node_val  [DLLE_POOL_ENTRIES];
    logic                node_used [DLLE_POOL_ENTRIES];
    logic [HANDLE_W-1:0] free_top;
    logic [COUNT_W-1:0]  live_count;

    t_list_result expected_results [$];
    int           results_seen;

    // Put the sentinel on itself and chain every other entry free in index order.
    function automatic void rebuild_pool();
        for (int i = 1; i < DLLE_POOL_ENTRIES; i++) begin
            link_next[i] = (i + 1 < DLLE_POOL_ENTRIES) ? i[HANDLE_W-1:0] + 1'b1 : SENTINEL;
            link_prev[i] = SENTINEL;
            node_used[i] = 1'b0;
        end
        link_next[SENTINEL] = SENTINEL;
        link_prev[SENTINEL] = SENTINEL;
        node_used[SENTINEL] = 1'b0;
        free_top            = 4'd1;
        live_count          = '0;
    endfunction

    // Take the head of the free chain and splice it in ahead of the given node.
    // Returns the new handle, or the sentinel when no entry is free.
    function automatic logic [HANDLE_W-1:0] link_node(input logic [HANDLE_W-1:0] at,
                                                      input logic [VALUE_W-1:0] val);
        logic [HANDLE_W-1:0] fresh;
        logic [HANDLE_W-1:0] behind;
        fresh = free_top;
        if (fresh != SENTINEL) begin
            free_top          = link_next[fresh];
            behind            = link_prev[at];
            node_val[fresh]   = val;
            node_used[fresh]  = 1'b1;
            link_next[fresh]  = at;
            link_prev[fresh]  = behind;
            link_prev[at]     = fresh;
            link_next[behind] = fresh;
            live_count        = live_count + 1'b1;
        end
        return fresh;
    endfunction

    // Bridge the neighbors of a node and push it onto the free chain.
    function automatic logic [VALUE_W-1:0] unlink_node(input logic [HANDLE_W-1:0] gone);
        logic [HANDLE_W-1:0] ahead;
        logic [HANDLE_W-1:0] after;
        ahead            = link_prev[gone];
        after            = link_next[gone];
        link_next[ahead] = after;
        link_prev[after] = ahead;
        node_used[gone]  = 1'b0;
        link_next[gone]  = free_top;
        link_prev[gone]  = SENTINEL;
        free_top         = gone;
        if (live_count != 0) begin
            live_count = live_count - 1'b1;
        end
        return node_val[gone];
    endfunction

    // Carry out one list operation on the private pool and return its result.
    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        t_list_result        res;
        logic [HANDLE_W-1:0] at;
        int                  steps;
        logic                hit;
        res        = '0;
        res.status = STAT_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_BEFORE: begin
                // The handle is judged before the pool is checked for room.
                if (op == OP_INSERT_BEFORE && pos != SENTINEL && !node_used[pos]) begin
                    res.status = STAT_BAD_HANDLE;
                end else begin
                    if (op == OP_PUSH_BACK) begin
                        at = SENTINEL;
                    end else if (op == OP_PUSH_FRONT) begin
                        at = link_next[SENTINEL];
                    end else begin
                        at = pos;
                    end
                    res.handle = link_node(at, val);
                    if (res.handle == SENTINEL) begin
                        res.status = STAT_POOL_FULL;
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (live_count == 0 || link_next[SENTINEL] == SENTINEL) begin
                    res.status = STAT_LIST_EMPTY;
                end else begin
                    at          = (op == OP_POP_BACK) ? link_prev[SENTINEL]
                                                      : link_next[SENTINEL];
                    res.handle  = at;
                    res.removed = unlink_node(at);
                end
            end
            OP_ERASE: begin
                if (pos == SENTINEL || !node_used[pos]) begin
                    res.status = STAT_BAD_HANDLE;
                end else begin
                    res.handle  = pos;
                    res.removed = unlink_node(pos);
                end
            end
            OP_FIND: begin
                // Walk from the front; the first matching node wins.
                at    = link_next[SENTINEL];
                hit   = 1'b0;
                steps = 0;
                while (steps < DLLE_POOL_ENTRIES && at != SENTINEL && !hit) begin
                    if (node_val[at] == val) begin
                        hit        = 1'b1;
                        res.handle = at;
                    end else begin
                        at = link_next[at];
                    end
                    steps++;
                end
                res.status = hit ? STAT_OK : STAT_NOT_FOUND;
            end
            OP_CLEAR: begin
                rebuild_pool();
            end
            default: begin
                // Query and unused codes leave the pool alone.
            end
        endcase
        res.count = live_count;
        res.empty = (live_count == 0);
        return res;
    endfunction

    // Print one mismatch line, up to a limit, and count it.
    task automatic report_mismatch(input string what);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: result %0d: %s", $time, results_seen, what);
        end
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Predict on each input transfer and compare on each output transfer.
    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DLLE_POOL_ENTRIES; i++) begin
                node_val[i] = '0;
            end
            rebuild_pool();
            expected_results.delete();
            results_seen = 0;
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(i_operation, i_value, i_position));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with no result expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", VALUE_W'(i_status), VALUE_W'(want.status));
                    check_field("handle", VALUE_W'(i_handle), VALUE_W'(want.handle));
                    check_field("removed_value", i_removed_value, want.removed);
                    check_field("count", VALUE_W'(i_count), VALUE_W'(want.count));
                    check_field("is_empty", VALUE_W'(i_is_empty), VALUE_W'(want.empty));
                end
                results_seen++;
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the list engine testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module testbench;
    import dlle_pkg::*;
    import dlle_tb_pkg::*;

    localparam int ITEM_TARGET      = 950;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 64;
    localparam int RECENT_DEPTH     = 32;
    localparam int TIMEOUT_NS       = 2_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_operation;
    logic [VALUE_W-1:0]  i_value;
    logic [POS_W-1:0]    i_position;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [2:0]          o_status;
    logic [HANDLE_W-1:0] o_handle;
    logic [VALUE_W-1:0]  o_removed_value;
    logic [COUNT_W-1:0]  o_count;
    logic                o_is_empty;

    int fail_count;
    int pending_results;

    // Stimulus state: burst pacing, stall control and values stored lately.
    int                 items_sent  = 0;
    int                 burst_left  = 0;
    bit                 gapless     = 1'b0;
    bit                 stall_free  = 1'b0;
    int                 hold_ticket = 0;
    logic [VALUE_W-1:0] recent_values [$];

    doubly_linked_list_engine DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_handle        (o_handle),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty)
    );

    list_result_checker u_results (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_handle        (o_handle),
        .i_removed_value (o_removed_value),
        .i_count         (o_count),
        .i_is_empty      (o_is_empty),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("doubly_linked_list_engine test failed");
        $finish;
    end

    // Receiver: random ready runs and stalls, free-running stretches, and a long
    // hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int hold_served;
        int run_len;
        hold_served = 0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_free) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run_len = $urandom_range(1, 10);
                i_out_ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                run_len = $urandom_range(0, 6);
                if (run_len > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (run_len) @(posedge i_clk);
                end
            end
        end
    end

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Offer one operation and hold it until the transfer; bursts are paced here.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!gapless) begin
                idle_sender($urandom_range(0, 6));
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        i_position  <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT || op == OP_INSERT_BEFORE) begin
            recent_values.push_back(val);
            if (recent_values.size() > RECENT_DEPTH) begin
                void'(recent_values.pop_front());
            end
        end
    endtask

    // Stop offering until every outstanding result has been taken.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // Data values: extremes, small values that collide often, and random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3, 4:    return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // One operation of a realistic mix; find keys mostly repeat stored values.
    task automatic send_mixed_item();
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            op = OP_PUSH_BACK;
        end else if (pick < 24) begin
            op = OP_PUSH_FRONT;
        end else if (pick < 38) begin
            op = OP_INSERT_BEFORE;
        end else if (pick < 48) begin
            op = OP_POP_BACK;
        end else if (pick < 56) begin
            op = OP_POP_FRONT;
        end else if (pick < 70) begin
            op = OP_ERASE;
        end else if (pick < 88) begin
            op = OP_FIND;
        end else if (pick < 95) begin
            op = OP_QUERY;
        end else if (pick < 97) begin
            op = OP_CLEAR;
        end else begin
            op = OP_W'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX));
        end
        val = pick_value();
        if (op == OP_FIND && recent_values.size() != 0 && $urandom_range(0, 2) != 0) begin
            val = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end
        send_item(op, val, POS_W'($urandom_range(0, DLLE_POOL_ENTRIES - 1)));
    endtask

    // Main stimulus.
    initial begin : stimulus
        int kind;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = '0;
        i_value     = '0;
        i_position  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every error on an empty list first, then a small list.
        gapless = 1'b1;
        send_item(OP_QUERY, '0, SENTINEL);
        send_item(OP_POP_BACK, '0, SENTINEL);
        send_item(OP_POP_FRONT, '0, SENTINEL);
        send_item(OP_ERASE, '0, SENTINEL);
        send_item(OP_ERASE, '0, 4'd9);
        send_item(OP_INSERT_BEFORE, 32'd1, 4'd3);
        send_item(OP_FIND, '0, SENTINEL);
        send_item(OP_PUSH_BACK, 32'h7FFF_FFFF, SENTINEL);
        send_item(OP_PUSH_FRONT, 32'h8000_0000, SENTINEL);
        send_item(OP_PUSH_BACK, '1, SENTINEL);
        // Inserting before the sentinel appends.
        send_item(OP_INSERT_BEFORE, '0, SENTINEL);
        send_item(OP_INSERT_BEFORE, 32'd5, 4'd1);
        send_item(OP_FIND, '1, SENTINEL);
        send_item(OP_FIND, 32'h0000_3039, SENTINEL);
        send_item(OP_ERASE, '0, 4'd15);
        send_item(OP_ERASE, '0, 4'd2);
        send_item(OP_POP_BACK, '0, SENTINEL);
        send_item(OP_POP_FRONT, '0, SENTINEL);
        send_item(OP_W'(OP_CLEAR + 1), '1, 4'd7);
        send_item(OP_CODE_MAX, 32'h5A5A_A5A5, 4'd8);
        send_item(OP_CLEAR, '0, SENTINEL);
        send_item(OP_QUERY, '0, SENTINEL);
        wait_for_results();

        // Fill the pool past its end, then try to insert into the full pool.
        gapless = 1'b0;
        repeat (DLLE_POOL_ENTRIES + 1) send_item(OP_PUSH_BACK, pick_value(), SENTINEL);
        send_item(OP_INSERT_BEFORE, pick_value(), 4'd1);
        send_item(OP_INSERT_BEFORE, pick_value(), SENTINEL);

        // Long output stall while input keeps coming, so the input backs up.
        hold_ticket <= hold_ticket + 1;
        gapless = 1'b1;
        repeat (20) send_mixed_item();
        wait_for_results();

        // Random episodes until the item budget is spent.
        while (items_sent < ITEM_TARGET) begin
            kind        = $urandom_range(0, 9);
            gapless     = ($urandom_range(0, 3) == 0);
            stall_free <= ($urandom_range(0, 4) == 0);
            case (kind)
                0, 1: begin
                    repeat ($urandom_range(10, 18)) begin
                        send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                                  pick_value(),
                                  POS_W'($urandom_range(0, DLLE_POOL_ENTRIES - 1)));
                    end
                end
                2: begin
                    repeat ($urandom_range(10, 18)) begin
                        send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
                                  pick_value(),
                                  POS_W'($urandom_range(0, DLLE_POOL_ENTRIES - 1)));
                    end
                end
                3: begin
                    hold_ticket <= hold_ticket + 1;
                    repeat (24) send_mixed_item();
                end
                4: begin
                    // Noise: any code, any handle, any value.
                    repeat (8) begin
                        send_item(OP_W'($urandom_range(0, OP_CODE_MAX)), $urandom(),
                                  POS_W'($urandom_range(0, DLLE_POOL_ENTRIES - 1)));
                    end
                end
                5: begin
                    wait_for_results();
                    repeat ($urandom_range(10, 30)) send_mixed_item();
                end
                default: begin
                    repeat ($urandom_range(10, 40)) send_mixed_item();
                end
            endcase
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("doubly_linked_list_engine test passed");
        end else begin
            $display("doubly_linked_list_engine test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/dlle_pkg.sv
design/dlle_ctrl.sv
design/dlle_dpath.sv
design/doubly_linked_list_engine.sv
design/dlle_checker.sv
dv/dlle_tb_pkg.sv
dv/list_result_checker.sv
dv/testbench.sv
